// ===== hw/rtl/tra_pkg.sv =====
package tra_pkg;

    // Opcodes
    localparam logic [1:0] OP_TRACE = 2'd0;
    localparam logic [1:0] OP_TAINT = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Scheduler incident kinds
    localparam logic [1:0] KIND_DISPATCH = 2'd0;
    localparam logic [1:0] KIND_STOP     = 2'd1;

    // Register select (paddr[2])
    localparam logic REG_SCHED_TAG  = 1'b0;
    localparam logic REG_AREA_WORDS = 1'b1;

    localparam int            AREA_W     = 21;
    localparam logic [20:0]   AREA_MAX   = 21'h100000;
    localparam int            HASH_STEPS = 8;     // 32-bit id, 4 bits per step

    typedef struct packed {
        logic [1:0]  opcode;
        logic [19:0] read_pointer;
        logic [15:0] packet_length;
        logic [31:0] packet_tag;
        logic [31:0] thread_id;
        logic [31:0] timebase;
        logic [1:0]  incident_kind;
        logic [6:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [19:0] next_read_pointer;
        logic        slot_found;
        logic        table_full;
        logic        taint_out;
        logic [31:0] read_thread_id;
        logic [63:0] read_run_time;
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_HASH,
        ST_PROBE,
        ST_CHECK,
        ST_UPDATE,
        ST_TAINT,
        ST_FRAME,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_FOUND,
        RES_FULL,
        RES_READ
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     cnt_clr;
        logic     mod_init;
        logic     mod_step;
        logic     probe_init;
        logic     probe_next;
        logic     rd_en;
        logic     rd_slot;
        logic     latch;
        logic     update;
        logic     clr_thread;
        logic     clr_disp;
        logic     clr_run;
        logic     sweep_next;
        logic     set_taint;
        logic     clr_taint;
        logic     res_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       sched;
        logic       mod_last;
        logic       hit;
        logic       probe_last;
        logic       sweep_last;
        logic       res_free;
    } status_t;

endpackage

// ===== hw/rtl/thread_runtime_accounting.sv =====
// Channel   Dir  Handshake              Payload
// req       in   req_valid/req_ready    req_data (req_t): one opcode and its operands
// res       out  res_valid/res_ready    res_data (res_t): one result per request
// cfg       in   APB psel/penable/...   sched_tag @0x0, trace_area_words @0x4
//
// One request at a time; reads and non-scheduler packets go from decode straight to the
// result, scheduler packets first hash the thread id and then probe slots (read, check),
// up to every slot when the table is full; taint and begin-frame sweep every slot.
// The next request is accepted the cycle after the result loads, even if it waits.
// Reset starts a clearing pass over every slot of the slot RAMs; req_ready stays low
// during it, config writes still land. An unread result stalls only the next result.
module thread_runtime_accounting
    import tra_pkg::*;
#(
    parameter int SLOTS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req_data,
    // result channel
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]       sched_tag_reg;
    logic [AREA_W-1:0] area_words_reg;
    logic              cfg_wr;
    cmd_t              cmd;
    status_t           stat;

    // register file: only paddr[2] selects, low bits ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_tag_reg  <= 32'd0;
            area_words_reg <= AREA_MAX;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SCHED_TAG)
            begin
                sched_tag_reg <= pwdata;
            end
            else
            begin
                area_words_reg <= pwdata[AREA_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_AREA_WORDS) ? {{(32-AREA_W){1'b0}}, area_words_reg}
                                                 : sched_tag_reg;

    // sequencer
    tra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // hash unit, slot RAMs, update arithmetic, result register
    tra_dp #(.SLOTS(SLOTS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_data   (req_data),
        .sched_tag  (sched_tag_reg),
        .area_words (area_words_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule

// ===== hw/rtl/tra_ram.sv =====
module tra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tra_ctrl.sv =====
module tra_ctrl
    import tra_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  status_t stat,
    output cmd_t    cmd
);

    state_t   state_reg, state_next;
    res_sel_t res_sel_reg, res_sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            res_sel_reg <= RES_PLAIN;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        cmd          = '0;
        cmd.res_sel  = res_sel_reg;
        req_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_thread = 1'b1;
                cmd.clr_disp   = 1'b1;
                cmd.clr_run    = 1'b1;
                cmd.sweep_next = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.cnt_clr  = 1'b1;
                res_sel_next = RES_PLAIN;
                case (stat.op)
                    OP_TRACE:
                    begin
                        if (stat.sched)
                        begin
                            cmd.mod_init = 1'b1;
                            state_next   = ST_HASH;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                    OP_TAINT:
                    begin
                        cmd.set_taint = 1'b1;
                        state_next    = ST_TAINT;
                    end
                    OP_FRAME:
                    begin
                        cmd.clr_taint = 1'b1;
                        state_next    = ST_FRAME;
                    end
                    OP_READ:
                    begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_slot  = 1'b1;
                        res_sel_next = RES_READ;
                        state_next   = ST_RESULT;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_HASH:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.latch = 1'b1;
                if (stat.hit)
                begin
                    state_next = ST_UPDATE;
                end
                else if (stat.probe_last)
                begin
                    res_sel_next = RES_FULL;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_PROBE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update   = 1'b1;
                res_sel_next = RES_FOUND;
                state_next   = ST_RESULT;
            end
            ST_TAINT:
            begin
                cmd.clr_disp   = 1'b1;
                cmd.sweep_next = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_FRAME:
            begin
                cmd.clr_run    = 1'b1;
                cmd.sweep_next = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.res_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tra_dp.sv =====
module tra_dp
    import tra_pkg::*;
#(
    parameter int SLOTS = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           stat,
    input  req_t              req_data,
    input  logic [31:0]       sched_tag,
    input  logic [AREA_W-1:0] area_words,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int IW = ((AW > 7) ? AW : 7) + 1;
    localparam logic [AW:0]   SLOTS_W   = (AW + 1)'(SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [IW-1:0] SLOTS_IW  = IW'(SLOTS);

    req_t        in_reg;
    logic [AW-1:0] rem_reg, idx_reg, cnt_reg;
    logic [31:0] mshift_reg;
    logic [2:0]  mcnt_reg;
    logic [31:0] delta_reg;
    logic [63:0] run_reg;
    logic        disp_nz_reg;
    logic        taint_reg;
    logic        res_valid_reg;
    res_t        res_reg;

    logic [AW-1:0] rem_step;
    logic [AW:0]   rem_work;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [IW-1:0] slot_ext;
    logic          slot_in_range;
    logic [31:0]   thr_rd, disp_rd;
    logic [63:0]   run_rd;
    logic          thr_we, disp_we, run_we;
    logic [31:0]   thr_wd, disp_wd;
    logic [63:0]   run_wd;
    logic [AREA_W-1:0] area_eff, ptr_sum;
    logic [19:0]   next_ptr;
    res_t          res_next;

    // remainder of thread_id by SLOTS, four bits per cycle
    always_comb
    begin
        rem_work = {1'b0, rem_reg};
        for (int i = 0; i < 4; i++)
        begin
            rem_work = {rem_work[AW-1:0], mshift_reg[31-i]};
            if (rem_work >= SLOTS_W)
            begin
                rem_work = rem_work - SLOTS_W;
            end
        end
        rem_step = rem_work[AW-1:0];
    end

    assign slot_ext      = {{(IW-7){1'b0}}, in_reg.slot_index};
    assign slot_in_range = slot_ext < SLOTS_IW;
    assign rd_addr       = cmd.rd_slot ? slot_ext[AW-1:0] : idx_reg;
    assign wr_addr       = cmd.update ? idx_reg : cnt_reg;

    // pointer advance with wrap at the area end
    assign area_eff = (area_words > AREA_MAX) ? AREA_MAX : area_words;
    assign ptr_sum  = {1'b0, in_reg.read_pointer} + {4'b0, in_reg.packet_length, 1'b0};
    assign next_ptr = (ptr_sum >= area_eff) ? 20'd0 : ptr_sum[19:0];

    always_comb
    begin
        thr_we  = cmd.clr_thread || cmd.update;
        thr_wd  = cmd.update ? in_reg.thread_id : 32'd0;
        disp_we = cmd.clr_disp;
        disp_wd = 32'd0;
        run_we  = cmd.clr_run;
        run_wd  = 64'd0;
        if (cmd.update)
        begin
            if (in_reg.incident_kind == KIND_DISPATCH)
            begin
                disp_we = 1'b1;
                disp_wd = in_reg.timebase;
            end
            else if (in_reg.incident_kind == KIND_STOP && disp_nz_reg)
            begin
                disp_we = 1'b1;
                run_we  = 1'b1;
                run_wd  = run_reg + {32'd0, delta_reg};
            end
        end
    end

    tra_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_thread_ram (
        .clk   (clk),
        .we    (thr_we),
        .waddr (wr_addr),
        .wdata (thr_wd),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (thr_rd)
    );

    tra_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_disp_ram (
        .clk   (clk),
        .we    (disp_we),
        .waddr (wr_addr),
        .wdata (disp_wd),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (disp_rd)
    );

    tra_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (wr_addr),
        .wdata (run_wd),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (run_rd)
    );

    always_comb
    begin
        res_next                   = '0;
        res_next.next_read_pointer = (in_reg.opcode == OP_TRACE) ? next_ptr : 20'd0;
        res_next.slot_found        = (cmd.res_sel == RES_FOUND);
        res_next.table_full        = (cmd.res_sel == RES_FULL);
        res_next.taint_out         = taint_reg;
        if (cmd.res_sel == RES_READ && slot_in_range)
        begin
            res_next.read_thread_id = thr_rd;
            res_next.read_run_time  = run_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= req_data;
        end
        if (cmd.mod_init)
        begin
            rem_reg    <= '0;
            mshift_reg <= in_reg.thread_id;
            mcnt_reg   <= 3'd0;
        end
        else if (cmd.mod_step)
        begin
            rem_reg    <= rem_step;
            mshift_reg <= {mshift_reg[27:0], 4'd0};
            mcnt_reg   <= mcnt_reg + 3'd1;
        end
        if (cmd.probe_init)
        begin
            idx_reg <= rem_step;
        end
        else if (cmd.probe_next)
        begin
            idx_reg <= (idx_reg == LAST_SLOT) ? '0 : idx_reg + AW'(1);
        end
        if (cmd.latch)
        begin
            delta_reg   <= in_reg.timebase - disp_rd;
            run_reg     <= run_rd;
            disp_nz_reg <= (disp_rd != 32'd0);
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            taint_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr || cmd.probe_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.sweep_next || cmd.probe_next)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            if (cmd.set_taint)
            begin
                taint_reg <= 1'b1;
            end
            else if (cmd.clr_taint)
            begin
                taint_reg <= 1'b0;
            end
            else if (cmd.update && in_reg.incident_kind == KIND_STOP && !disp_nz_reg)
            begin
                taint_reg <= 1'b1;
            end
            if (cmd.res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.op         = in_reg.opcode;
        stat.sched      = (in_reg.packet_tag == sched_tag);
        stat.mod_last   = (mcnt_reg == 3'(HASH_STEPS - 1));
        stat.hit        = (thr_rd == in_reg.thread_id) ||
                          (disp_rd == 32'd0 && run_rd == 64'd0);
        stat.probe_last = (cnt_reg == LAST_SLOT);
        stat.sweep_last = (cnt_reg == LAST_SLOT);
        stat.res_free   = !res_valid_reg || res_ready;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// ===== verif/tb_top.sv =====
module tb_top
    import tra_pkg::*;
();

    // Table depth used by the scoreboard mirror; must match the DUT parameter.
    localparam int SLOT_COUNT = 128;
    localparam int POOL_SIZE  = 10;
    localparam int BUCKETS    = 3;

    // Register byte addresses. The register select is paddr[2].
    localparam logic [2:0] ADDR_SCHED_TAG  = {REG_SCHED_TAG, 2'b00};
    localparam logic [2:0] ADDR_AREA_WORDS = {REG_AREA_WORDS, 2'b00};

    // Quiet cycles after the last result between phases, and at the very end.
    // The end wait covers a full-table probe plus margin.
    localparam int SETTLE_PHASE = 8;
    localparam int SETTLE_END   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_t        res_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Idle rates in percent: the request side inserts gaps, the result side
    // drops res_ready. Changed per phase by the main sequence.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;

    int unsigned mismatch_count = 0;

    // Mirror of the accounting table and config; the predictor owns the table, apb_write the config.
    logic [31:0] mirror_owner [SLOT_COUNT];
    logic [31:0] mirror_stamp [SLOT_COUNT];
    logic [63:0] mirror_ticks [SLOT_COUNT];
    logic        mirror_taint;
    logic [31:0] cfg_sched_tag;
    logic [20:0] cfg_area_words;

    // Predicted results, oldest first.
    res_t pending_results [$];
    res_t want_res;

    always #10 clk = ~clk;

    thread_runtime_accounting #(
        .SLOTS(SLOT_COUNT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data(res_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // ------------------------------------------------------------------
    // Predictor: applies one request to the mirror and returns its result.
    // ------------------------------------------------------------------
    function automatic res_t account_request(input req_t r);
        res_t        o;
        logic [31:0] area;
        logic [31:0] nxt;
        logic [31:0] delta;
        int unsigned start;
        int unsigned idx;
        logic        hit;

        o = '0;
        idx = 0;
        hit = 1'b0;
        case (r.opcode)
            OP_TRACE:
            begin
                // Area above the max is clamped; zero area makes every packet wrap.
                area = (cfg_area_words > AREA_MAX) ? 32'(AREA_MAX) : 32'(cfg_area_words);
                nxt = 32'(r.read_pointer) + {15'b0, r.packet_length, 1'b0};
                if (nxt >= area)
                    nxt = '0;
                o.next_read_pointer = nxt[19:0];
                if (r.packet_tag == cfg_sched_tag)
                begin
                    // Linear probe from the home bucket: stop on a match or claim
                    // the first slot with zero stamp and zero run time.
                    start = r.thread_id % SLOT_COUNT;
                    for (int n = 0; n < SLOT_COUNT && !hit; n++)
                    begin
                        idx = (start + n) % SLOT_COUNT;
                        if (mirror_owner[idx] == r.thread_id)
                            hit = 1'b1;
                        else if (mirror_stamp[idx] == '0 && mirror_ticks[idx] == '0)
                        begin
                            mirror_owner[idx] = r.thread_id;
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        o.table_full = 1'b1;
                    else
                    begin
                        o.slot_found = 1'b1;
                        if (r.incident_kind == KIND_DISPATCH)
                            mirror_stamp[idx] = r.timebase;
                        else if (r.incident_kind == KIND_STOP)
                        begin
                            // Stop without a recorded dispatch taints the frame.
                            if (mirror_stamp[idx] != '0)
                            begin
                                delta = r.timebase - mirror_stamp[idx];
                                mirror_ticks[idx] += 64'(delta);
                                mirror_stamp[idx] = '0;
                            end
                            else
                                mirror_taint = 1'b1;
                        end
                    end
                end
            end
            OP_TAINT:
            begin
                for (int n = 0; n < SLOT_COUNT; n++)
                    mirror_stamp[n] = '0;
                mirror_taint = 1'b1;
            end
            OP_FRAME:
            begin
                for (int n = 0; n < SLOT_COUNT; n++)
                    mirror_ticks[n] = '0;
                mirror_taint = 1'b0;
            end
            default:
            begin
                if (r.slot_index < SLOT_COUNT)
                begin
                    o.read_thread_id = mirror_owner[r.slot_index];
                    o.read_run_time  = mirror_ticks[r.slot_index];
                end
            end
        endcase
        o.taint_out = mirror_taint;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Request builders. Fields that do not matter for the opcode stay random
    // so every payload bit toggles.
    // ------------------------------------------------------------------
    function automatic req_t random_request();
        req_t r;
        r.opcode        = 2'($urandom);
        r.read_pointer  = 20'($urandom);
        r.packet_length = ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(64));
        r.packet_tag    = $urandom;
        r.thread_id     = $urandom;
        r.timebase      = $urandom;
        r.incident_kind = 2'($urandom);
        r.slot_index    = 7'($urandom);
        return r;
    endfunction

    function automatic req_t op_request(input logic [1:0] op);
        req_t r;
        r = random_request();
        r.opcode = op;
        return r;
    endfunction

    function automatic req_t sched_request(input logic [31:0] tid, input logic [1:0] kind,
                                           input logic [31:0] tb);
        req_t r;
        r = op_request(OP_TRACE);
        r.packet_tag    = cfg_sched_tag;
        r.thread_id     = tid;
        r.incident_kind = kind;
        r.timebase      = tb;
        return r;
    endfunction

    function automatic req_t read_request(input logic [6:0] slot);
        req_t r;
        r = op_request(OP_READ);
        r.slot_index = slot;
        return r;
    endfunction

    function automatic req_t pointer_request(input logic [19:0] rp, input logic [15:0] len);
        req_t r;
        r = op_request(OP_TRACE);
        r.read_pointer  = rp;
        r.packet_length = len;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bus tasks. All start and end on a rising edge.
    // ------------------------------------------------------------------

    // Optional random gap, then hold valid until accepted. Valid stays high on
    // exit so back-to-back requests never toggle it within one step.
    task automatic send_request(input req_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        pending_results.push_back(account_request(r));
    endtask

    // Drop valid and let every outstanding result come back.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_PHASE) @(posedge clk);
    endtask

    // Setup + access phase; the register lands on the access edge.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_SCHED_TAG)
            cfg_sched_tag = data;
        else
            cfg_area_words = data[20:0];
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order checking.
    // ------------------------------------------------------------------
    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= stall_pct);

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, got %h", $time, res_data);
            end
            else
            begin
                want_res = pending_results.pop_front();
                compare_field("next_read_pointer", 64'(want_res.next_read_pointer),
                              64'(res_data.next_read_pointer));
                compare_field("slot_found", 64'(want_res.slot_found), 64'(res_data.slot_found));
                compare_field("table_full", 64'(want_res.table_full), 64'(res_data.table_full));
                compare_field("taint_out", 64'(want_res.taint_out), 64'(res_data.taint_out));
                compare_field("read_thread_id", 64'(want_res.read_thread_id),
                              64'(res_data.read_thread_id));
                compare_field("read_run_time", want_res.read_run_time, res_data.read_run_time);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked requests: empty reads, pointer extremes, dispatch/stop with
    // timebase wrap, stop with no dispatch, zero timebase dispatch, other
    // incident kinds, bucket collisions, taint and begin-frame clears.
    task automatic test_directed();
        apb_write(ADDR_SCHED_TAG, 32'hFFFF_FFFF);
        apb_write(ADDR_AREA_WORDS, 32'(AREA_MAX));
        send_request(read_request(7'd0));
        send_request(pointer_request(20'hFFFFF, 16'hFFFF));
        send_request(pointer_request(20'h00000, 16'h0000));
        send_request(pointer_request(20'd1000, 16'd5));
        // thread FFFFFFFF hashes to the top slot; stop before dispatch time
        // so the 32-bit difference wraps
        send_request(sched_request(32'hFFFF_FFFF, KIND_DISPATCH, 32'd100));
        send_request(sched_request(32'hFFFF_FFFF, KIND_STOP, 32'd50));
        send_request(read_request(7'd127));
        send_request(sched_request(32'hFFFF_FFFF, KIND_STOP, 32'd75));
        send_request(op_request(OP_FRAME));
        send_request(read_request(7'd127));
        // zero timebase dispatch looks like no dispatch at all
        send_request(sched_request(32'd5, KIND_DISPATCH, 32'd0));
        send_request(sched_request(32'd5, KIND_STOP, 32'd7));
        send_request(sched_request(32'd133, 2'd2, 32'hFFFF_FFFF));
        send_request(sched_request(32'd6, 2'd3, 32'h1234_5678));
        send_request(sched_request(32'd5, KIND_DISPATCH, 32'hFFFF_FFFF));
        send_request(sched_request(32'd261, KIND_DISPATCH, 32'd1));
        send_request(sched_request(32'd5, KIND_STOP, 32'd9));
        send_request(op_request(OP_TAINT));
        send_request(sched_request(32'd261, KIND_STOP, 32'd3));
        send_request(read_request(7'd5));
        send_request(read_request(7'd6));
        send_request(op_request(OP_FRAME));
    endtask

    // Area register extremes, including zero and values above the clamp.
    task automatic test_pointer_wrap();
        wait_idle();
        apb_write(ADDR_AREA_WORDS, 32'd1);
        send_request(pointer_request(20'd0, 16'd0));
        wait_idle();
        apb_write(ADDR_AREA_WORDS, 32'd0);
        send_request(pointer_request(20'd0, 16'd0));
        wait_idle();
        apb_write(ADDR_AREA_WORDS, 32'h1F_FFFF);
        send_request(pointer_request(20'hFFFFF, 16'd0));
        send_request(pointer_request(20'hFFFFE, 16'd1));
        wait_idle();
        apb_write(ADDR_AREA_WORDS, 32'd1000);
        send_request(pointer_request(20'd990, 16'd5));
        send_request(pointer_request(20'd990, 16'd4));
    endtask

    // Fill every slot with a running thread, then push new threads into the
    // full table. Top id bits keep ids unique, low bits collide in buckets.
    task automatic test_table_full();
        logic [31:0] ids [SLOT_COUNT];
        logic [31:0] tb;

        wait_idle();
        apb_write(ADDR_SCHED_TAG, $urandom);
        send_request(op_request(OP_TAINT));
        send_request(op_request(OP_FRAME));
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            ids[i] = {7'(i), 25'($urandom)};
            tb = $urandom;
            if (tb == '0)
                tb = 32'd1;
            send_request(sched_request(ids[i], KIND_DISPATCH, tb));
        end
        for (int i = 0; i < 3; i++)
            send_request(sched_request($urandom, KIND_DISPATCH, $urandom));
        // existing threads still resolve while full
        send_request(sched_request(ids[5], KIND_STOP, $urandom));
        send_request(sched_request(ids[9], 2'd2, $urandom));
        send_request(read_request(7'($urandom)));
        send_request(sched_request($urandom, KIND_STOP, $urandom));
        // taint drops every stamp, which frees all slots with no run time
        send_request(op_request(OP_TAINT));
        send_request(sched_request($urandom, KIND_DISPATCH, $urandom));
    endtask

    // Random traffic dominated by dispatch/stop pairs from a small thread pool
    // packed into a few buckets, with reads, noise packets and clears mixed in.
    task automatic test_mixed_traffic(input int count, input logic [31:0] tag,
                                      input logic [31:0] area);
        logic [31:0] pool [POOL_SIZE];
        logic        running [POOL_SIZE];
        logic [6:0]  buckets [BUCKETS];
        logic [1:0]  kind;
        req_t        r;
        int unsigned roll;
        int unsigned k;

        wait_idle();
        apb_write(ADDR_SCHED_TAG, tag);
        apb_write(ADDR_AREA_WORDS, area);
        for (int b = 0; b < BUCKETS; b++)
            buckets[b] = 7'($urandom);
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            pool[p] = {25'($urandom), buckets[$urandom_range(BUCKETS - 1)]};
            running[p] = 1'b0;
        end
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 65)
            begin
                k = $urandom_range(POOL_SIZE - 1);
                if ($urandom_range(9) < 8)
                    kind = running[k] ? KIND_STOP : KIND_DISPATCH;
                else
                    kind = 2'($urandom);
                if (kind == KIND_DISPATCH)
                    running[k] = 1'b1;
                else if (kind == KIND_STOP)
                    running[k] = 1'b0;
                r = sched_request(pool[k], kind, $urandom);
            end
            else if (roll < 73)
                r = sched_request($urandom, 2'($urandom), $urandom);
            else if (roll < 83)
            begin
                r = op_request(OP_TRACE);
                if (r.packet_tag == cfg_sched_tag)
                    r.packet_tag[0] = ~r.packet_tag[0];
            end
            else if (roll < 93)
            begin
                if ($urandom_range(1) == 1)
                    r = read_request(buckets[$urandom_range(BUCKETS - 1)] + 7'($urandom_range(3)));
                else
                    r = read_request(7'($urandom));
            end
            else
            begin
                r = op_request((roll < 96) ? OP_TAINT : OP_FRAME);
                if (roll < 96)
                    for (int p = 0; p < POOL_SIZE; p++)
                        running[p] = 1'b0;
            end
            send_request(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int n = 0; n < SLOT_COUNT; n++)
        begin
            mirror_owner[n] = '0;
            mirror_stamp[n] = '0;
            mirror_ticks[n] = '0;
        end
        mirror_taint   = 1'b0;
        cfg_sched_tag  = '0;
        cfg_area_words = AREA_MAX;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Phase 1: sender mostly busy, receiver stalls a lot.
        send_idle_pct = 24;
        stall_pct     = 87;
        test_directed();
        test_pointer_wrap();
        test_mixed_traffic(90, $urandom, $urandom_range(1, 32'(AREA_MAX)));

        // Phase 2: roles swapped.
        send_idle_pct = 87;
        stall_pct     = 24;
        test_table_full();
        test_mixed_traffic(90, 32'd0, 32'(AREA_MAX));

        // Phase 3: full throughput both sides.
        send_idle_pct = 0;
        stall_pct     = 0;
        test_mixed_traffic(100, 32'hFFFF_FFFF, $urandom_range(1, 32'(AREA_MAX)));

        wait_idle();
        repeat (SETTLE_END) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every packet a full probe
    // under heavy stalls).
    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tra_pkg.sv
hw/rtl/tra_ram.sv
hw/rtl/tra_ctrl.sv
hw/rtl/tra_dp.sv
hw/rtl/thread_runtime_accounting.sv
verif/tb_top.sv
